[hw/rtl/bidla_pkg.sv]
// ----------------------------------------------------------------------------
// bidla_pkg
// Shared constants, codes and types of the bouncing walk step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bidla_pkg;

  // grid geometry
  localparam int GRID_SIZE = 256;
  localparam int CW        = $clog2(GRID_SIZE);
  localparam int GRID_MID  = GRID_SIZE / 2;
  // signed offset width: holds offsets, gains up to 255 and one jump on top
  localparam int OW        = ((CW > 8) ? CW : 8) + 2;

  typedef logic [CW-1:0]         coord_t;
  typedef logic signed [OW-1:0]  offs_t;
  typedef logic [GRID_SIZE-1:0]  row_t;

  localparam offs_t OFF_LO  = offs_t'(-GRID_MID);
  localparam offs_t OFF_HI  = offs_t'(GRID_MID - 1);
  localparam offs_t OFF_MID = offs_t'(GRID_MID);

  // configuration register indexes
  localparam logic [1:0] CFG_BOUNCE_MODE = 2'd0;
  localparam logic [1:0] CFG_GAIN_A      = 2'd1;
  localparam logic [1:0] CFG_GAIN_B      = 2'd2;

  // bounce rule codes
  localparam logic [3:0] MODE_NONE = 4'd0;
  localparam logic [3:0] MODE_IDLA = 4'd1;
  localparam logic [3:0] MODE_SIGN = 4'd2;
  localparam logic [3:0] MODE_SIG2 = 4'd3;
  localparam logic [3:0] MODE_SOFT = 4'd4;
  localparam logic [3:0] MODE_MAXI = 4'd5;
  localparam logic [3:0] MODE_MAX2 = 4'd6;
  localparam logic [3:0] MODE_DENT = 4'd7;
  localparam logic [3:0] MODE_OCTO = 4'd8;

  // step direction codes
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_PY = 2'd1;
  localparam logic [1:0] DIR_NX = 2'd2;
  localparam logic [1:0] DIR_NY = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic   clr_we;
    coord_t clr_row;
    logic   accept;
    logic   commit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/bidla_ram.sv]
// ----------------------------------------------------------------------------
// bidla_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bidla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held when no read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bidla_ctrl.sv]
// ----------------------------------------------------------------------------
// bidla_ctrl
// Controller: grid clearing pass after reset, request accept and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bidla_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                out_stall,
  input  wire bidla_pkg::dp_sts_t  sts,
  output bidla_pkg::ctl_cmd_t      cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  localparam bidla_pkg::coord_t LAST_ROW = bidla_pkg::coord_t'(bidla_pkg::GRID_SIZE - 1);

  logic [1:0]        state_r, state_nxt;
  bidla_pkg::coord_t clr_cnt_r, clr_cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd         = '0;
    cmd.clr_row = clr_cnt_r;
    in_stall    = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // wait for room in the output register
        cmd.commit = !(sts.out_full && out_stall);
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bidla_dp.sv]
// ----------------------------------------------------------------------------
// bidla_dp
// Datapath: walker position, occupancy grid, bounce rules and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bidla_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bidla_pkg::ctl_cmd_t cmd,
  output bidla_pkg::dp_sts_t       sts,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic [1:0]          in_step_dir,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_site_filled,
  output logic [7:0]               out_fill_x,
  output logic [7:0]               out_fill_y,
  output logic                     out_walk_done
);

  localparam bidla_pkg::coord_t MAX_COORD =
    bidla_pkg::coord_t'(bidla_pkg::GRID_SIZE - 1);

  // -a*sgn style scaling: minus k for positive, plus k for negative
  function automatic bidla_pkg::offs_t neg_sc(input logic p, input logic n,
                                              input bidla_pkg::offs_t k);
    return p ? -k : (n ? k : '0);
  endfunction

  // configuration registers
  logic [3:0] mode_r;
  logic [7:0] gain_a_r;
  logic [7:0] gain_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bidla_pkg::MODE_IDLA;
      gain_a_r <= 8'd2;
      gain_b_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bidla_pkg::CFG_BOUNCE_MODE: mode_r   <= cfg_wdata[3:0];
        bidla_pkg::CFG_GAIN_A:      gain_a_r <= cfg_wdata;
        bidla_pkg::CFG_GAIN_B:      gain_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // walker state
  bidla_pkg::coord_t wx_r, wy_r, wx_nxt, wy_nxt;
  logic              fin_r, fin_nxt;

  // stepped site, latched with the request
  bidla_pkg::coord_t stx, sty, stx_r, sty_r;
  logic              st_off, st_off_r;

  always_comb begin
    stx    = wx_r;
    sty    = wy_r;
    st_off = 1'b0;
    case (in_step_dir)
      bidla_pkg::DIR_PX: begin
        stx    = wx_r + 1'b1;
        st_off = (wx_r == MAX_COORD);
      end
      bidla_pkg::DIR_PY: begin
        sty    = wy_r + 1'b1;
        st_off = (wy_r == MAX_COORD);
      end
      bidla_pkg::DIR_NX: begin
        stx    = wx_r - 1'b1;
        st_off = (wx_r == '0);
      end
      bidla_pkg::DIR_NY: begin
        sty    = wy_r - 1'b1;
        st_off = (wy_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stx_r    <= stx;
      sty_r    <= sty;
      st_off_r <= st_off;
    end
  end

  // occupancy grid, one row per word
  logic              ram_we;
  bidla_pkg::coord_t ram_waddr;
  bidla_pkg::row_t   ram_wdata, row_a, row_b;

  bidla_ram #(
    .WIDTH (bidla_pkg::GRID_SIZE),
    .DEPTH (bidla_pkg::GRID_SIZE)
  ) u_grid (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.accept),
    .raddr_a (wy_r),
    .raddr_b (sty),
    .rdata_a (row_a),
    .rdata_b (row_b)
  );

  // step decision
  logic              cur_occ, moved, end_step, do_fill;
  bidla_pkg::coord_t px, py;

  always_comb begin
    cur_occ  = row_a[wx_r];
    moved    = cur_occ;
    end_step = cur_occ && st_off_r;
    px       = moved ? stx_r : wx_r;
    py       = moved ? sty_r : wy_r;
    do_fill  = !fin_r && !end_step && !(moved && row_b[stx_r]);
  end

  // bounce rule on the filled site's offset
  bidla_pkg::offs_t ox, oy, ax, ay, ka, kb, k, jx, jy, sxy, dxy, adxy;
  logic             xp, xn, yp, yn;
  logic [7:0]       a_half;

  always_comb begin
    ox     = bidla_pkg::offs_t'(px) - bidla_pkg::OFF_MID;
    oy     = bidla_pkg::offs_t'(py) - bidla_pkg::OFF_MID;
    xp     = (ox > 0);
    xn     = ox[bidla_pkg::OW-1];
    yp     = (oy > 0);
    yn     = oy[bidla_pkg::OW-1];
    ax     = xn ? -ox : ox;
    ay     = yn ? -oy : oy;
    ka     = bidla_pkg::offs_t'(gain_a_r);
    kb     = bidla_pkg::offs_t'(gain_b_r);
    a_half = (gain_a_r - 8'd1) >> 1;
    sxy    = ox + oy;
    dxy    = ox - oy;
    adxy   = dxy[bidla_pkg::OW-1] ? -dxy : dxy;
    k      = bidla_pkg::offs_t'(1);
    jx     = '0;
    jy     = '0;
    case (mode_r)
      bidla_pkg::MODE_IDLA: begin
        jx = -ox;
        jy = -oy;
      end
      bidla_pkg::MODE_SIGN: begin
        jx = neg_sc(xp, xn, k);
        jy = neg_sc(yp, yn, k);
      end
      bidla_pkg::MODE_SIG2: begin
        if ((xp && yp) || (xn && yn)) begin
          k = ka;
        end else if ((xp && yn) || (xn && yp)) begin
          k = bidla_pkg::offs_t'(1);
        end else if (gain_a_r == '0) begin
          k = bidla_pkg::offs_t'(1);
        end else begin
          k = bidla_pkg::offs_t'(a_half) + bidla_pkg::offs_t'(1);
        end
        jx = neg_sc(xp, xn, k);
        jy = neg_sc(yp, yn, k);
      end
      bidla_pkg::MODE_SOFT: begin
        if (ox > (ay <<< 1)) begin
          k = ka;
        end
        jx = neg_sc(xp, xn, k);
        jy = neg_sc(yp, yn, k);
      end
      bidla_pkg::MODE_MAXI: begin
        if (ax > ay) begin
          jx = neg_sc(xp, xn, k);
        end else begin
          jy = neg_sc(yp, yn, k);
        end
      end
      bidla_pkg::MODE_MAX2: begin
        if (ax > ay) begin
          jx = neg_sc(xp, xn, k);
        end else begin
          jy = neg_sc(yp, yn, ka);
        end
      end
      bidla_pkg::MODE_DENT: begin
        if (sxy > (adxy <<< 1)) begin
          if (oy > ox) begin
            jx = -k;
          end else begin
            jy = -k;
          end
        end else if (ay > ax) begin
          jy = neg_sc(yp, yn, k);
        end else begin
          jx = neg_sc(xp, xn, k);
        end
      end
      bidla_pkg::MODE_OCTO: begin
        if (ax > (ay <<< 1)) begin
          jx = neg_sc(xp, xn, ka);
        end else if (ay > (ax <<< 1)) begin
          jy = neg_sc(yp, yn, ka);
        end else begin
          jx = neg_sc(xp, xn, kb);
          jy = neg_sc(yp, yn, kb);
        end
      end
      default: ;
    endcase
  end

  // landing site after the jump
  bidla_pkg::offs_t nxo, nyo, gxo, gyo;
  logic             jump_off;

  always_comb begin
    nxo      = ox + jx;
    nyo      = oy + jy;
    gxo      = nxo + bidla_pkg::OFF_MID;
    gyo      = nyo + bidla_pkg::OFF_MID;
    jump_off = (nxo < bidla_pkg::OFF_LO) || (nxo > bidla_pkg::OFF_HI) ||
               (nyo < bidla_pkg::OFF_LO) || (nyo > bidla_pkg::OFF_HI);
    fin_nxt  = fin_r || end_step || (do_fill && jump_off);
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    if (!fin_nxt) begin
      wx_nxt = do_fill ? gxo[bidla_pkg::CW-1:0] : px;
      wy_nxt = do_fill ? gyo[bidla_pkg::CW-1:0] : py;
    end
  end

  // grid write: clearing pass or filling the site
  always_comb begin
    ram_we    = cmd.clr_we || (cmd.commit && do_fill);
    ram_waddr = cmd.clr_we ? cmd.clr_row : py;
    ram_wdata = cmd.clr_we ? '0
                           : ((moved ? row_b : row_a) | (bidla_pkg::row_t'(1) << px));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r  <= bidla_pkg::coord_t'(bidla_pkg::GRID_MID);
      wy_r  <= bidla_pkg::coord_t'(bidla_pkg::GRID_MID);
      fin_r <= 1'b0;
    end else if (cmd.commit) begin
      wx_r  <= wx_nxt;
      wy_r  <= wy_nxt;
      fin_r <= fin_nxt;
    end
  end

  // result register
  logic       out_valid_r;
  logic       filled_r;
  logic [7:0] fill_x_r, fill_y_r;
  logic       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      filled_r <= do_fill;
      fill_x_r <= do_fill ? 8'(px) : 8'd0;
      fill_y_r <= do_fill ? 8'(py) : 8'd0;
      done_r   <= fin_nxt;
    end
  end

  assign sts.out_full    = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_site_filled = filled_r;
  assign out_fill_x      = fill_x_r;
  assign out_fill_y      = fill_y_r;
  assign out_walk_done   = done_r;

endmodule

`default_nettype wire

[hw/rtl/bouncing_idla_walk_step.sv]
// ----------------------------------------------------------------------------
// bouncing_idla_walk_step
// Top level of the bouncing internal aggregation walker, one step per request.
// ----------------------------------------------------------------------------
// Each request is one iteration of the walker and gives exactly one result.
// After reset the block clears the occupancy grid one row per cycle;
// in_stall stays high until that pass is done, while configuration writes
// are taken at any time. A request is then accepted in ST_IDLE, where both
// candidate grid rows (walker site and stepped site) are read from the row
// memory; in ST_EVAL the site is decided, filled, the bounce jump applied
// and the result loaded into the output register. ST_EVAL waits while a
// previous result is still held by out_stall. The walker position written
// in ST_EVAL feeds the next request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bouncing_idla_walk_step (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_step_dir,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_site_filled,
  output logic [7:0]      out_fill_x,
  output logic [7:0]      out_fill_y,
  output logic            out_walk_done
);

  bidla_pkg::ctl_cmd_t cmd;
  bidla_pkg::dp_sts_t  sts;

  // sequencing
  bidla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // walker, grid and result register
  bidla_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_step_dir     (in_step_dir),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_site_filled (out_site_filled),
    .out_fill_x      (out_fill_x),
    .out_fill_y      (out_fill_y),
    .out_walk_done   (out_walk_done)
  );

endmodule

`default_nettype wire
